/* rtl/core/scm_pkg.sv */
// ----------------------------------------------------------------------------
// scm_pkg
// Shared types and constants of the pseudocolour map lookup pipeline.
// ----------------------------------------------------------------------------
package scm_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned SIZE_W      = $clog2(MAX_ENTRIES) + 1;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned RATIO_W     = FRAC_BITS + 2;
  localparam int unsigned ENTRY_W     = 16;
  localparam int unsigned TYPE_W      = 4;
  localparam int unsigned CFG_W       = SIZE_W;
  // Numerators and denominators reach twice the largest ramp length.
  localparam int unsigned OP_W        = SIZE_W + 1;
  localparam int unsigned REM_W       = OP_W + 1;
  // One quotient bit above the fraction shows that the value reached one.
  localparam int unsigned Q_W         = FRAC_BITS + 1;
  localparam int unsigned DIV_STEPS   = FRAC_BITS + 1;
  localparam int unsigned STEPS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES  = (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  localparam logic [FRAC_BITS-1:0] VAL_FULL  = '1;
  // floor(0.4 * 2^FRAC_BITS)
  localparam logic [FRAC_BITS-1:0] VAL_FIXED = FRAC_BITS'((2 << FRAC_BITS) / 5);

  localparam logic REG_MAP_TYPE = 1'b0;
  localparam logic REG_MAP_SIZE = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

  typedef enum logic [TYPE_W-1:0] {
    MAP_GRAY   = 4'd0,
    MAP_RED    = 4'd1,
    MAP_GREEN  = 4'd2,
    MAP_BLUE   = 4'd3,
    MAP_JET    = 4'd4,
    MAP_SPRING = 4'd5,
    MAP_SUMMER = 4'd6,
    MAP_AUTUMN = 4'd7,
    MAP_WINTER = 4'd8,
    MAP_HOT    = 4'd9,
    MAP_COOL   = 4'd10
  } map_e;

  typedef enum logic [1:0] {
    CH_ZERO  = 2'd0,
    CH_FULL  = 2'd1,
    CH_FIXED = 2'd2,
    CH_DIV   = 2'd3
  } ch_mode_e;

  // Values that follow from the map size alone.
  typedef struct packed {
    logic [SIZE_W-1:0] den;
    logic [OP_W-1:0]   jet_n;
    logic [OP_W-1:0]   jet_len;
    logic [OP_W-1:0]   jet_off;
    logic [OP_W-1:0]   jet_gsize;
    logic [OP_W-1:0]   hot_n;
    logic [OP_W-1:0]   hot_den;
  } size_t;

  typedef struct packed {
    ch_mode_e        mode;
    logic [OP_W-1:0] num;
    logic [OP_W-1:0] den;
  } ch_op_t;

endpackage

/* rtl/core/scm_index.sv */
// ----------------------------------------------------------------------------
// scm_index
// Two register stages: input capture, then entry number and size constants.
// ----------------------------------------------------------------------------
module scm_index (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             vld_i,
  input  logic                             cmd_i,
  input  logic signed [scm_pkg::RATIO_W-1:0] ratio_i,
  input  logic [scm_pkg::ENTRY_W-1:0]      entry_index_i,
  input  logic [scm_pkg::SIZE_W-1:0]       map_size_i,
  output logic                             vld_o,
  output logic [scm_pkg::IDX_W-1:0]        idx_o,
  output scm_pkg::size_t                   sz_o
);

  localparam int unsigned R_W    = scm_pkg::FRAC_BITS + 1;
  localparam int unsigned PROD_W = R_W + scm_pkg::SIZE_W;
  localparam int unsigned OP_W   = scm_pkg::OP_W;

  logic                          vld_a_q, vld_b_q;
  logic                          cmd_q;
  logic [R_W-1:0]                r_q, r_d;
  logic [scm_pkg::ENTRY_W-1:0]   entry_q;
  logic [scm_pkg::SIZE_W-1:0]    size_q, size_d;
  logic [scm_pkg::IDX_W-1:0]     idx_q, idx_d;
  scm_pkg::size_t                sz_q, sz_d;

  logic [PROD_W-1:0]             prod;
  logic [scm_pkg::SIZE_W-1:0]    last;
  logic [PROD_W-scm_pkg::FRAC_BITS-1:0] by_ratio;
  logic [OP_W-1:0]               gend, jsum, m_ext;

  // Clamp the ratio to 0..1 and the size to 1..MAX_ENTRIES.
  always_comb begin
    if (ratio_i[scm_pkg::RATIO_W-1]) begin
      r_d = '0;
    end else if (ratio_i > $signed(scm_pkg::RATIO_W'(1 << scm_pkg::FRAC_BITS))) begin
      r_d = R_W'(1 << scm_pkg::FRAC_BITS);
    end else begin
      r_d = ratio_i[R_W-1:0];
    end
    if (map_size_i == '0) begin
      size_d = scm_pkg::SIZE_W'(1);
    end else if (map_size_i > scm_pkg::SIZE_W'(scm_pkg::MAX_ENTRIES)) begin
      size_d = scm_pkg::SIZE_W'(scm_pkg::MAX_ENTRIES);
    end else begin
      size_d = map_size_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_i;
    r_q     <= r_d;
    entry_q <= entry_index_i;
    size_q  <= size_d;
    idx_q   <= idx_d;
    sz_q    <= sz_d;
  end

  // Entry number, clamped to the last entry.
  always_comb begin
    prod     = PROD_W'(r_q) * PROD_W'(size_q);
    by_ratio = prod[PROD_W-1:scm_pkg::FRAC_BITS];
    last     = size_q - scm_pkg::SIZE_W'(1);
    idx_d    = last[scm_pkg::IDX_W-1:0];
    if (cmd_q) begin
      if (scm_pkg::ENTRY_W'(entry_q) <= scm_pkg::ENTRY_W'(last)) begin
        idx_d = entry_q[scm_pkg::IDX_W-1:0];
      end
    end else begin
      if (by_ratio <= ($bits(by_ratio))'(last)) begin
        idx_d = by_ratio[scm_pkg::IDX_W-1:0];
      end
    end
  end

  // Denominator of the linear maps; ramp lengths and offsets of the jet and hot maps.
  always_comb begin
    m_ext          = OP_W'(size_q);
    sz_d.den       = (size_q > scm_pkg::SIZE_W'(1)) ? last : scm_pkg::SIZE_W'(1);
    sz_d.jet_n     = (m_ext + OP_W'(3)) >> 2;
    sz_d.jet_len   = OP_W'(3) * sz_d.jet_n - OP_W'(1);
    sz_d.jet_off   = ((sz_d.jet_n + OP_W'(1)) >> 1)
                   - ((size_q[1:0] == 2'd1) ? OP_W'(1) : OP_W'(0));
    jsum           = sz_d.jet_off + sz_d.jet_len;
    gend           = (jsum < m_ext) ? jsum : m_ext;
    sz_d.jet_gsize = (gend > sz_d.jet_off) ? gend - sz_d.jet_off : '0;
    sz_d.hot_n     = (OP_W'(3) * m_ext) >> 3;
    sz_d.hot_den   = m_ext - (sz_d.hot_n << 1);
  end

  assign vld_o = vld_b_q;
  assign idx_o = idx_q;
  assign sz_o  = sz_q;

endmodule

/* rtl/core/scm_setup.sv */
// ----------------------------------------------------------------------------
// scm_setup
// Chooses for each colour channel a constant or a numerator and denominator.
// ----------------------------------------------------------------------------
module scm_setup (
  input  logic [scm_pkg::TYPE_W-1:0] map_type_i,
  input  logic [scm_pkg::IDX_W-1:0]  idx_i,
  input  scm_pkg::size_t             sz_i,
  output scm_pkg::ch_op_t            red_o,
  output scm_pkg::ch_op_t            green_o,
  output scm_pkg::ch_op_t            blue_o
);

  localparam int unsigned S_W = scm_pkg::OP_W + 2;

  typedef logic signed [S_W-1:0] sv_t;

  function automatic scm_pkg::ch_op_t mk_div(input sv_t num, input sv_t den);
    scm_pkg::ch_op_t op;
    op.num  = num[scm_pkg::OP_W-1:0];
    op.den  = den[scm_pkg::OP_W-1:0];
    op.mode = (num <= 0 || den <= 0) ? scm_pkg::CH_ZERO : scm_pkg::CH_DIV;
    return op;
  endfunction

  function automatic scm_pkg::ch_op_t mk_const(input scm_pkg::ch_mode_e mode);
    scm_pkg::ch_op_t op;
    op.mode = mode;
    op.num  = '0;
    op.den  = '0;
    return op;
  endfunction

  // One jet ramp: position k on its shifted window, u read at pos.
  function automatic scm_pkg::ch_op_t jet_ch(input sv_t k, input sv_t pos, input sv_t n,
                                             input sv_t gsize);
    sv_t a, b, m;
    a = pos + sv_t'(1);
    b = sv_t'(3) * n - sv_t'(1) - pos;
    m = (a < n) ? a : n;
    m = (m < b) ? m : b;
    if (k >= 0 && k < gsize) begin
      return mk_div(m, n);
    end
    return mk_const(scm_pkg::CH_ZERO);
  endfunction

  sv_t i, den, jn, jlen, joff, jgs, hn, hden;
  sv_t kr, kg, kb;

  always_comb begin
    i    = sv_t'(idx_i);
    den  = sv_t'(sz_i.den);
    jn   = sv_t'(sz_i.jet_n);
    jlen = sv_t'(sz_i.jet_len);
    joff = sv_t'(sz_i.jet_off);
    jgs  = sv_t'(sz_i.jet_gsize);
    hn   = sv_t'(sz_i.hot_n);
    hden = sv_t'(sz_i.hot_den);
    kr   = i - jn - joff;
    kg   = i - joff;
    kb   = i + jn - joff;

    red_o   = mk_const(scm_pkg::CH_ZERO);
    green_o = mk_const(scm_pkg::CH_ZERO);
    blue_o  = mk_const(scm_pkg::CH_ZERO);

    case (map_type_i)
      scm_pkg::MAP_GRAY: begin
        red_o   = mk_div(i, den);
        green_o = mk_div(i, den);
        blue_o  = mk_div(i, den);
      end
      scm_pkg::MAP_RED:   red_o   = mk_div(i, den);
      scm_pkg::MAP_GREEN: green_o = mk_div(i, den);
      scm_pkg::MAP_BLUE:  blue_o  = mk_div(i, den);
      scm_pkg::MAP_JET: begin
        red_o   = jet_ch(kr, kr, jn, jgs);
        green_o = jet_ch(kg, kg, jn, jgs);
        blue_o  = jet_ch(kb, jlen - jgs + kb, jn, jgs);
      end
      scm_pkg::MAP_SPRING: begin
        red_o   = mk_const(scm_pkg::CH_FULL);
        green_o = mk_div(i, den);
        blue_o  = mk_div(den - i, den);
      end
      scm_pkg::MAP_SUMMER: begin
        red_o   = mk_div(i, den);
        green_o = mk_div(den + i, den <<< 1);
        blue_o  = mk_const(scm_pkg::CH_FIXED);
      end
      scm_pkg::MAP_AUTUMN: begin
        red_o   = mk_const(scm_pkg::CH_FULL);
        green_o = mk_div(i, den);
      end
      scm_pkg::MAP_WINTER: begin
        green_o = mk_div(i, den);
        blue_o  = mk_div((den <<< 1) - i, den <<< 1);
      end
      scm_pkg::MAP_HOT: begin
        red_o = (i < hn) ? mk_div(i + sv_t'(1), hn) : mk_const(scm_pkg::CH_FULL);
        if (i < hn) begin
          green_o = mk_const(scm_pkg::CH_ZERO);
        end else if (i < (hn <<< 1)) begin
          green_o = mk_div(i - hn + sv_t'(1), hn);
        end else begin
          green_o = mk_const(scm_pkg::CH_FULL);
        end
        blue_o = (i < (hn <<< 1)) ? mk_const(scm_pkg::CH_ZERO)
                                  : mk_div(i - (hn <<< 1) + sv_t'(1), hden);
      end
      scm_pkg::MAP_COOL: begin
        red_o   = mk_div(i, den);
        green_o = mk_div(den - i, den);
        blue_o  = mk_const(scm_pkg::CH_FULL);
      end
      default: begin
        red_o = mk_const(scm_pkg::CH_ZERO);
      end
    endcase
  end

endmodule

/* rtl/core/scm_div.sv */
// ----------------------------------------------------------------------------
// scm_div
// Pipelined restoring divider: floor(num*2^FRAC_BITS/den) for num <= den, saturated.
// ----------------------------------------------------------------------------
module scm_div (
  input  logic                          clk_i,
  input  scm_pkg::ch_op_t               op_i,
  output logic [scm_pkg::FRAC_BITS-1:0] value_o
);

  localparam int unsigned NST   = scm_pkg::DIV_STAGES;
  localparam int unsigned SPS   = scm_pkg::STEPS_PER_STAGE;
  localparam int unsigned REM_W = scm_pkg::REM_W;
  localparam int unsigned Q_W   = scm_pkg::Q_W;

  logic [REM_W-1:0]         rem_q  [NST+1];
  logic [Q_W-1:0]           quo_q  [NST+1];
  logic [scm_pkg::OP_W-1:0] den_q  [NST+1];
  scm_pkg::ch_mode_e        mode_q [NST+1];

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= REM_W'(op_i.num);
    quo_q[0]  <= '0;
    den_q[0]  <= op_i.den;
    mode_q[0] <= op_i.mode;
  end

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [REM_W-1:0] rem, sh;
    logic [Q_W-1:0]   quo;

    always_comb begin
      rem = rem_q[s];
      quo = quo_q[s];
      sh  = '0;
      for (int t = 0; t < SPS; t++) begin
        if (s * SPS + t < scm_pkg::DIV_STEPS) begin
          // The first step compares without shifting: it yields the units bit.
          sh = (s * SPS + t == 0) ? rem : {rem[REM_W-2:0], 1'b0};
          if (sh >= REM_W'(den_q[s])) begin
            quo = {quo[Q_W-2:0], 1'b1};
            rem = sh - REM_W'(den_q[s]);
          end else begin
            quo = {quo[Q_W-2:0], 1'b0};
            rem = sh;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= rem;
      quo_q[s+1]  <= quo;
      den_q[s+1]  <= den_q[s];
      mode_q[s+1] <= mode_q[s];
    end
  end

  always_comb begin
    case (mode_q[NST])
      scm_pkg::CH_FULL:  value_o = scm_pkg::VAL_FULL;
      scm_pkg::CH_FIXED: value_o = scm_pkg::VAL_FIXED;
      scm_pkg::CH_DIV:   value_o = quo_q[NST][Q_W-1] ? scm_pkg::VAL_FULL
                                                    : quo_q[NST][Q_W-2:0];
      default:           value_o = '0;
    endcase
  end

endmodule

/* rtl/core/scalar_to_rgb_colormap.sv */
// ----------------------------------------------------------------------------
// scalar_to_rgb_colormap
// Pseudocolour mapper: turns a scalar or an entry number into an RGB colour.
// ----------------------------------------------------------------------------
//
// Channel      Direction  Handshake            Payload
// command      in         start, busy          cmd_i, ratio_i, entry_index_i
// result       out        done_o (strobe)      red_o, green_o, blue_o, used_index_o
// config       in         cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// A transaction is taken at every clock edge with start high; busy is held low,
// because the pipeline never stalls. Each result is strobed by done_o for one
// cycle, in command order. On its way a command passes the two index stages,
// the divider input register, the nine divider stages (two quotient bits each,
// one in the last) and the output register.
// Reset returns the map type to jet and the map size to 64 and empties the
// pipeline; the receiver cannot stall, so nothing is ever held back.
//
module scalar_to_rgb_colormap (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cmd_i,
  input  logic signed [scm_pkg::RATIO_W-1:0]  ratio_i,
  input  logic [scm_pkg::ENTRY_W-1:0]         entry_index_i,
  output logic                                done_o,
  output logic [scm_pkg::FRAC_BITS-1:0]       red_o,
  output logic [scm_pkg::FRAC_BITS-1:0]       green_o,
  output logic [scm_pkg::FRAC_BITS-1:0]       blue_o,
  output logic [scm_pkg::IDX_W-1:0]           used_index_o,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [scm_pkg::CFG_W-1:0]           cfg_wdata_i
);

  // The divider input register plus its stages.
  localparam int unsigned DLY = scm_pkg::DIV_STAGES + 1;

  logic [scm_pkg::TYPE_W-1:0] map_type_q;
  logic [scm_pkg::SIZE_W-1:0] map_size_q;

  logic                       accept;
  logic                       idx_vld;
  logic [scm_pkg::IDX_W-1:0]  idx;
  scm_pkg::size_t             sz;
  scm_pkg::ch_op_t            red_op, green_op, blue_op;
  logic [scm_pkg::FRAC_BITS-1:0] red_v, green_v, blue_v;

  logic                       vld_q [DLY];
  logic [scm_pkg::IDX_W-1:0]  idx_q [DLY];

  logic                          done_q;
  logic [scm_pkg::FRAC_BITS-1:0] red_q, green_q, blue_q;
  logic [scm_pkg::IDX_W-1:0]     used_q;

  // Every cycle can take a transaction.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Configuration registers; writes must only happen while the pipeline is empty, which the block does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_type_q <= scm_pkg::MAP_JET;
      map_size_q <= scm_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == scm_pkg::REG_MAP_TYPE) begin
        map_type_q <= cfg_wdata_i[scm_pkg::TYPE_W-1:0];
      end else begin
        map_size_q <= cfg_wdata_i[scm_pkg::SIZE_W-1:0];
      end
    end
  end

  scm_index u_index (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vld_i         (accept),
    .cmd_i         (cmd_i),
    .ratio_i       (ratio_i),
    .entry_index_i (entry_index_i),
    .map_size_i    (map_size_q),
    .vld_o         (idx_vld),
    .idx_o         (idx),
    .sz_o          (sz)
  );

  scm_setup u_setup (
    .map_type_i (map_type_q),
    .idx_i      (idx),
    .sz_i       (sz),
    .red_o      (red_op),
    .green_o    (green_op),
    .blue_o     (blue_op)
  );

  // One divider for each colour channel, running in lock step.
  scm_div u_div_red   (.clk_i(clk_i), .op_i(red_op),   .value_o(red_v));
  scm_div u_div_green (.clk_i(clk_i), .op_i(green_op), .value_o(green_v));
  scm_div u_div_blue  (.clk_i(clk_i), .op_i(blue_op),  .value_o(blue_v));

  // Valid bits and entry numbers travel alongside the divider stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DLY; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[0] <= idx_vld;
      for (int k = 1; k < DLY; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q[0] <= idx;
    for (int k = 1; k < DLY; k++) begin
      idx_q[k] <= idx_q[k-1];
    end
  end

  // Output register: the result is shown for exactly one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[DLY-1];
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_v;
    green_q <= green_v;
    blue_q  <= blue_v;
    used_q  <= idx_q[DLY-1];
  end

  assign done_o       = done_q;
  assign red_o        = red_q;
  assign green_o      = green_q;
  assign blue_o       = blue_q;
  assign used_index_o = used_q;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the pseudocolour mapper against a predictor of its own. Commands
// are driven with random gaps and every strobed result is compared, field by
// field, with the oldest predicted colour. The map registers are rewritten
// between phases once the pipeline has drained.
// ----------------------------------------------------------------------------

class colour_scoreboard;
  logic [15:0] exp_red_q[$];
  logic [15:0] exp_green_q[$];
  logic [15:0] exp_blue_q[$];
  logic [9:0]  exp_idx_q[$];
  int          n_errors;

  // Records the colour that an accepted command must produce.
  function void note_command(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                             logic [9:0] idx);
    exp_red_q   = {exp_red_q, r};
    exp_green_q = {exp_green_q, g};
    exp_blue_q  = {exp_blue_q, b};
    exp_idx_q   = {exp_idx_q, idx};
  endfunction

  function void check_colour(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                             logic [9:0] idx);
    logic [15:0] er, eg, eb;
    logic [9:0]  ei;
    if (exp_red_q.size() == 0) begin
      $error("result with no command outstanding");
      n_errors++;
      return;
    end
    er = exp_red_q.pop_front();
    eg = exp_green_q.pop_front();
    eb = exp_blue_q.pop_front();
    ei = exp_idx_q.pop_front();
    if (r !== er) begin
      $error("red: expected %0d, got %0d", er, r);
      n_errors++;
    end
    if (g !== eg) begin
      $error("green: expected %0d, got %0d", eg, g);
      n_errors++;
    end
    if (b !== eb) begin
      $error("blue: expected %0d, got %0d", eb, b);
      n_errors++;
    end
    if (idx !== ei) begin
      $error("used_index: expected %0d, got %0d", ei, idx);
      n_errors++;
    end
  endfunction

  function int pending();
    return exp_red_q.size();
  endfunction
endclass

module tb_top;
  import scm_pkg::*;

  localparam int unsigned LATENCY = 13;
  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      cmd_i = 1'b0;
  logic signed [RATIO_W-1:0] ratio_i = '0;
  logic [ENTRY_W-1:0]        entry_index_i = '0;
  logic                      done_o;
  logic [FRAC_BITS-1:0]      red_o, green_o, blue_o;
  logic [IDX_W-1:0]          used_index_o;
  logic                      cfg_we_i = 1'b0;
  logic                      cfg_idx_i = REG_MAP_TYPE;
  logic [CFG_W-1:0]          cfg_wdata_i = '0;

  // Shadow copies of the two registers, as last written.
  logic [TYPE_W-1:0] cur_type;
  logic [SIZE_W-1:0] cur_size;

  int unsigned sender_idle_pct;
  colour_scoreboard sb = new();

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  scalar_to_rgb_colormap u_top (.*);

  // Results cannot be held off, so every strobed cycle is checked at once.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_colour(red_o, green_o, blue_o, used_index_o);
  end

  // Fixed-point value of num/den in 0..1, saturated below one.
  function automatic logic [15:0] frac_of(longint num, longint den);
    longint unsigned v;
    if (num <= 0 || den <= 0) return 16'd0;
    v = (longint'(num) << FRAC_BITS) / den;
    return (v >= ONE) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic longint min_of3(longint a, longint b, longint c);
    longint m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  // Works out the colour and the clamped entry of one command.
  task automatic predict_colour(input logic cmd, input logic [RATIO_W-1:0] ratio,
                                input logic [ENTRY_W-1:0] entry);
    longint sz, idx, den, n, len, off, gend, gsz, k, h;
    longint unsigned r;
    logic [15:0] rgb[3];
    rgb = '{16'd0, 16'd0, 16'd0};
    sz = cur_size;
    if (sz < 1) sz = 1;
    if (sz > MAX_ENTRIES) sz = MAX_ENTRIES;
    if (cmd == 1'b0) begin
      if (ratio[RATIO_W-1]) r = 0;
      else r = (ratio > ONE) ? ONE : ratio;
      idx = (r * sz) >> FRAC_BITS;
    end else begin
      idx = entry;
    end
    if (idx > sz - 1) idx = sz - 1;
    den = (sz - 1 > 1) ? sz - 1 : 1;
    case (cur_type)
      MAP_GRAY: begin
        rgb[0] = frac_of(idx, den);
        rgb[1] = rgb[0];
        rgb[2] = rgb[0];
      end
      MAP_RED:   rgb[0] = frac_of(idx, den);
      MAP_GREEN: rgb[1] = frac_of(idx, den);
      MAP_BLUE:  rgb[2] = frac_of(idx, den);
      MAP_JET: begin
        // Jet: one trapezoid per channel, shifted by a quarter of the map.
        n = (sz + 3) / 4;
        len = 3 * n - 1;
        off = (n + 1) / 2 - ((sz % 4 == 1) ? 1 : 0);
        gend = (off + len < sz) ? off + len : sz;
        gsz = gend - off;
        if (gsz < 0) gsz = 0;
        k = idx - n - off;
        if (k >= 0 && k < gsz) rgb[0] = frac_of(min_of3(k + 1, n, 3 * n - 1 - k), n);
        k = idx - off;
        if (k >= 0 && k < gsz) rgb[1] = frac_of(min_of3(k + 1, n, 3 * n - 1 - k), n);
        k = idx + n - off;
        if (k >= 0 && k < gsz) begin
          k = len - gsz + k;
          rgb[2] = frac_of(min_of3(k + 1, n, 3 * n - 1 - k), n);
        end
      end
      MAP_SPRING: begin
        rgb[0] = VAL_FULL;
        rgb[1] = frac_of(idx, den);
        rgb[2] = frac_of(den - idx, den);
      end
      MAP_SUMMER: begin
        rgb[0] = frac_of(idx, den);
        rgb[1] = frac_of(den + idx, 2 * den);
        rgb[2] = frac_of(2, 5);
      end
      MAP_AUTUMN: begin
        rgb[0] = VAL_FULL;
        rgb[1] = frac_of(idx, den);
      end
      MAP_WINTER: begin
        rgb[1] = frac_of(idx, den);
        rgb[2] = frac_of(2 * den - idx, 2 * den);
      end
      MAP_HOT: begin
        h = (3 * sz) >> 3;
        rgb[0] = (idx < h) ? frac_of(idx + 1, h) : VAL_FULL;
        if (idx < h) rgb[1] = 16'd0;
        else if (idx < 2 * h) rgb[1] = frac_of(idx - h + 1, h);
        else rgb[1] = VAL_FULL;
        rgb[2] = (idx < 2 * h) ? 16'd0 : frac_of(idx - 2 * h + 1, sz - 2 * h);
      end
      MAP_COOL: begin
        rgb[0] = frac_of(idx, den);
        rgb[1] = frac_of(den - idx, den);
        rgb[2] = VAL_FULL;
      end
      default: ; // undefined map types give black
    endcase
    sb.note_command(rgb[0], rgb[1], rgb[2], idx[9:0]);
  endtask

  // Register writes happen only with the pipeline empty.
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MAP_TYPE) cur_type = value[TYPE_W-1:0];
    else cur_size = value;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // Issues one command. start stays high across back-to-back commands and
  // is lowered only when the sender idles afterwards; each idle cycle is
  // drawn on its own, so the idle share of cycles matches the percentage.
  task automatic send_command(input logic cmd, input logic [RATIO_W-1:0] ratio,
                              input logic [ENTRY_W-1:0] entry);
    start         <= 1'b1;
    cmd_i         <= cmd;
    ratio_i       <= ratio;
    entry_index_i <= entry;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_colour(cmd, ratio, entry);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk_i);
    end
  endtask

  task automatic stop_sending();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_command();
    logic [RATIO_W-1:0] ratio;
    logic [ENTRY_W-1:0] entry;
    int unsigned sel;
    sel = $urandom_range(9);
    // Mostly in-range values, sometimes raw bits and the edges of the clamps.
    case (sel)
      0: ratio = RATIO_W'($urandom());
      1: ratio = RATIO_W'(ONE[RATIO_W-1:0] + $urandom_range(0, 3) - 1);
      default: ratio = RATIO_W'($urandom_range(0, 32'(ONE)));
    endcase
    sel = $urandom_range(9);
    case (sel)
      0: entry = ENTRY_W'($urandom());
      1: entry = ENTRY_W'(cur_size + $urandom_range(0, 2) - 1);
      default: entry = ENTRY_W'($urandom_range(0, cur_size));
    endcase
    send_command(1'($urandom_range(1)), ratio, entry);
  endtask

  initial begin
    logic [SIZE_W-1:0] sizes[$];
    cur_type = MAP_JET;
    cur_size = SIZE_RESET;
    sender_idle_pct = 8;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, then every map type at size zero, then jet above the largest map.
    send_command(1'b0, 18'h20000, 16'd0);     // negative ratio
    send_command(1'b0, 18'h1FFFF, 16'd0);     // ratio far above one
    send_command(1'b0, ONE[RATIO_W-1:0], 16'd0);
    send_command(1'b0, 18'd0, 16'd0);
    send_command(1'b1, 18'h0FFFF, 16'hFFFF);  // entry beyond the map
    send_command(1'b1, 18'd0, 16'd63);
    stop_sending();
    drain();
    write_reg(REG_MAP_SIZE, 11'd0);           // size zero behaves as one
    for (int t = 0; t < 16; t++) begin
      write_reg(REG_MAP_TYPE, CFG_W'(t[3:0]));
      send_command(1'b1, 18'd0, 16'd0);
      stop_sending();
      drain();
    end
    write_reg(REG_MAP_SIZE, 11'h7FF);         // above the largest map
    write_reg(REG_MAP_TYPE, CFG_W'(MAP_JET));
    send_command(1'b1, 18'd0, 16'hFFFF);
    send_command(1'b0, ONE[RATIO_W-1:0], 16'd0);
    stop_sending();
    drain();

    // Random phases over many settings, extremes included.
    sizes = '{11'd1, 11'd2, 11'd3, 11'd4, 11'd5, 11'd9, 11'd1024, 11'd64, 11'd1025};
    for (int p = 0; p < 45; p++) begin
      if (p == 15) sender_idle_pct = 76;
      if (p == 30) sender_idle_pct = 0;
      write_reg(REG_MAP_TYPE, CFG_W'($urandom_range(0, 11)));
      if (p < sizes.size()) write_reg(REG_MAP_SIZE, sizes[p]);
      else write_reg(REG_MAP_SIZE, CFG_W'(($urandom_range(0, 9) == 0)
                                          ? $urandom_range(1, 1024)
                                          : $urandom_range(1, 40)));
      repeat (30) random_command();
      stop_sending();
      drain();
    end

    if (sb.n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end
endmodule

/* scalar_to_rgb_colormap.f */
rtl/core/scm_pkg.sv
rtl/core/scm_index.sv
rtl/core/scm_setup.sv
rtl/core/scm_div.sv
rtl/core/scalar_to_rgb_colormap.sv
sim/tb_top.sv
